### design/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Word types, status codes and the character-to-sextet map of the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_status;
		logic [2:0] status_code;
		logic       end_of_string;
	} out_word_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR = 3'd1;
	localparam logic [2:0] ST_MIXED    = 3'd2;
	localparam logic [2:0] ST_BAD_PAD  = 3'd3;
	localparam logic [2:0] ST_TAIL     = 3'd4;

	localparam logic [7:0] CH_PAD   = 8'h3D; // '='
	localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
	localparam logic [7:0] CH_SLASH = 8'h2F; // '/'
	localparam logic [7:0] CH_DASH  = 8'h2D; // '-'
	localparam logic [7:0] CH_UNDER = 8'h5F; // '_'

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;

	// bit 6 set: not in either alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [7:0] t;
		t = 8'h00;
		sextet_of = 7'h40;
		case (ch) inside
			[CH_UPPER_A:CH_UPPER_Z]: begin
				t = ch - CH_UPPER_A;
				sextet_of = {1'b0, t[5:0]};
			end
			[CH_LOWER_A:CH_LOWER_Z]: begin
				t = ch - CH_LOWER_A + 8'd26;
				sextet_of = {1'b0, t[5:0]};
			end
			[CH_DIGIT_0:CH_DIGIT_9]: begin
				t = ch - CH_DIGIT_0 + 8'd52;
				sextet_of = {1'b0, t[5:0]};
			end
			CH_PLUS, CH_DASH: begin
				sextet_of = 7'd62;
			end
			CH_SLASH, CH_UNDER: begin
				sextet_of = 7'd63;
			end
			default: begin
				sextet_of = 7'h40;
			end
		endcase
	endfunction

endpackage

### design/b64d_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_out_fifo
// Small result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module b64d_out_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  b64d_pkg::out_word_t push_w0,
	input  b64d_pkg::out_word_t push_w1,
	output logic                room2,
	output logic                res_valid,
	input  logic                res_ready,
	output b64d_pkg::out_word_t res_word
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	b64d_pkg::out_word_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	assign res_valid = (count_q != '0);
	assign res_word  = mem_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;
	assign room2     = (count_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_w0;
		end
		if (push_n == 2'd2) begin
			mem_q[ptr_inc(wr_ptr_q)] <= push_w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("result queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room2) else $error("push without room");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd0 && !pop |=> count_q == $past(count_q))
		else $error("queue count moved while idle");

endmodule

### design/base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Strict base64 decoder, one character per word, standard or URL alphabet.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | word
//  ---------+-----+------------------------+---------------------------------
//  char     | in  | char_valid/char_ready  | char_code, is_last
//  res      | out | res_valid/res_ready    | data_byte, is_status,
//           |     |                        | status_code, end_of_string
//
//  One character a cycle while the queue has room for two words; a result
//  word passes the input stage and the result queue before it is offered.
//  A final character that also completes a byte gives two result words,
//  the data byte and then the status word, pushed into the queue together.
//  char_ready depends only on the input stage and the registered queue fill,
//  not on res_ready.
//  Reset clears the group state, the input stage and the queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  b64d_pkg::in_word_t char_word,
	output logic               res_valid,
	input  logic               res_ready,
	output b64d_pkg::out_word_t res_word
);

	logic               valid_s1;
	b64d_pkg::in_word_t word_s1;

	logic [1:0] gp_q;
	logic [5:0] ps_q;
	logic       std_q;
	logic       url_q;
	logic [1:0] pad_q;
	logic [2:0] err_q;

	logic [1:0] gp_n;
	logic [5:0] ps_n;
	logic       std_n;
	logic       url_n;
	logic [1:0] pad_n;
	logic [2:0] err_n;

	logic       room2;
	logic       adv;
	logic       emit;
	logic [7:0] byte_v;
	logic [6:0] sx;
	logic [7:0] ch;

	logic [1:0]          push_n;
	b64d_pkg::out_word_t push_w0;
	b64d_pkg::out_word_t push_w1;
	b64d_pkg::out_word_t data_w;
	b64d_pkg::out_word_t stat_w;

	assign adv        = valid_s1 && room2;
	assign char_ready = !valid_s1 || room2;
	assign ch         = word_s1.char_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			word_s1 <= char_word;
		end
	end

	always_comb begin
		gp_n   = gp_q;
		ps_n   = ps_q;
		std_n  = std_q;
		url_n  = url_q;
		pad_n  = pad_q;
		err_n  = err_q;
		emit   = 1'b0;
		byte_v = 8'h00;
		sx     = b64d_pkg::sextet_of(ch);

		if (err_q == b64d_pkg::ST_OK) begin
			if (ch == b64d_pkg::CH_PAD) begin
				if (pad_q == 2'd0 && gp_q == 2'd2) begin
					if (ps_q[3:0] != 4'h0) err_n = b64d_pkg::ST_TAIL;
					pad_n = 2'd1;
					gp_n  = 2'd3;
				end else if (pad_q == 2'd0 && gp_q == 2'd3) begin
					if (ps_q[1:0] != 2'h0) err_n = b64d_pkg::ST_TAIL;
					pad_n = 2'd1;
					gp_n  = 2'd0;
				end else if (pad_q == 2'd1 && gp_q == 2'd3) begin
					pad_n = 2'd2;
					gp_n  = 2'd0;
				end else begin
					err_n = b64d_pkg::ST_BAD_PAD;
				end
			end else if (pad_q != 2'd0) begin
				err_n = b64d_pkg::ST_BAD_PAD;
			end else if (sx[6]) begin
				err_n = b64d_pkg::ST_BAD_CHAR;
			end else begin
				if (ch == b64d_pkg::CH_PLUS || ch == b64d_pkg::CH_SLASH) begin
					if (url_q) err_n = b64d_pkg::ST_MIXED;
					std_n = 1'b1;
				end else if (ch == b64d_pkg::CH_DASH || ch == b64d_pkg::CH_UNDER) begin
					if (std_q) err_n = b64d_pkg::ST_MIXED;
					url_n = 1'b1;
				end
				if (err_n == b64d_pkg::ST_OK) begin
					case (gp_q)
						2'd1:    byte_v = {ps_q, sx[5:4]};
						2'd2:    byte_v = {ps_q[3:0], sx[5:2]};
						2'd3:    byte_v = {ps_q[1:0], sx[5:0]};
						default: byte_v = 8'h00;
					endcase
					emit = (gp_q != 2'd0);
					ps_n = sx[5:0];
					gp_n = gp_q + 2'd1;
				end
			end
		end

		// end-of-string checks on the updated group state
		if (word_s1.is_last && err_n == b64d_pkg::ST_OK) begin
			if (pad_n != 2'd0) begin
				if (gp_n != 2'd0) err_n = b64d_pkg::ST_BAD_PAD;
			end else if (gp_n == 2'd1) begin
				err_n = b64d_pkg::ST_BAD_PAD;
			end else if (gp_n == 2'd2) begin
				if (ps_n[3:0] != 4'h0) err_n = b64d_pkg::ST_TAIL;
			end else if (gp_n == 2'd3) begin
				if (ps_n[1:0] != 2'h0) err_n = b64d_pkg::ST_TAIL;
			end
		end
	end

	always_comb begin
		data_w.data_byte     = byte_v;
		data_w.is_status     = 1'b0;
		data_w.status_code   = b64d_pkg::ST_OK;
		data_w.end_of_string = 1'b0;
		stat_w.data_byte     = 8'h00;
		stat_w.is_status     = 1'b1;
		stat_w.status_code   = err_n;
		stat_w.end_of_string = 1'b1;

		push_n  = 2'd0;
		push_w0 = data_w;
		push_w1 = stat_w;
		if (adv) begin
			if (emit && word_s1.is_last) begin
				push_n = 2'd2;
			end else if (emit) begin
				push_n = 2'd1;
			end else if (word_s1.is_last) begin
				push_n  = 2'd1;
				push_w0 = stat_w;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q  <= 2'd0;
			ps_q  <= 6'd0;
			std_q <= 1'b0;
			url_q <= 1'b0;
			pad_q <= 2'd0;
			err_q <= b64d_pkg::ST_OK;
		end else if (adv) begin
			if (word_s1.is_last) begin
				gp_q  <= 2'd0;
				ps_q  <= 6'd0;
				std_q <= 1'b0;
				url_q <= 1'b0;
				pad_q <= 2'd0;
				err_q <= b64d_pkg::ST_OK;
			end else begin
				gp_q  <= gp_n;
				ps_q  <= ps_n;
				std_q <= std_n;
				url_q <= url_n;
				pad_q <= pad_n;
				err_q <= err_n;
			end
		end
	end

	b64d_out_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_w0  (push_w0),
		.push_w1  (push_w1),
		.room2    (room2),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_word (res_word)
	);

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && word_s1.is_last |=> gp_q == 2'd0 && pad_q == 2'd0 &&
		err_q == b64d_pkg::ST_OK && !std_q && !url_q)
		else $error("state not cleared after final character");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != b64d_pkg::ST_OK && !(adv && word_s1.is_last) |=>
		err_q == $past(err_q)) else $error("error code changed mid-string");

	a_pad_position: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q != 2'd0 |-> gp_q == 2'd0 || gp_q == 2'd3)
		else $error("padding seen at impossible group position");

	a_no_mixed_flags: assert property (@(posedge clk) disable iff (!arst_n)
		std_q && url_q |-> err_q == b64d_pkg::ST_MIXED)
		else $error("both alphabets seen without mixed-alphabet error");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the base64 stream decoder. Directed strings cover
// both alphabets, padding, tail bits and each status code. Random strings
// follow, mostly well formed with some corrupted and some pure noise, under
// three idling regimes. A local decoder model predicts every result word, and
// the monitor compares each accepted result word against it in order.
// ----------------------------------------------------------------------------
module testbench;

	typedef logic [7:0] text_t[$];

	localparam int ITEMS_PER_PHASE = 570;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                char_valid = 1'b0;
	logic                char_ready;
	b64d_pkg::in_word_t  char_word  = '0;
	logic                res_valid;
	logic                res_ready  = 1'b0;
	b64d_pkg::out_word_t res_word;

	b64d_pkg::in_word_t  char_queue[$];
	b64d_pkg::out_word_t decoded_words[$];
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        queued_items  = 0;
	bit        char_fired    = 1'b0;
	bit        failed        = 1'b0;

	// model of the decoder's group state
	logic [1:0] grp_pos     = 2'd0;
	logic [5:0] prev_sextet = 6'd0;
	logic       seen_std    = 1'b0;
	logic       seen_url    = 1'b0;
	logic [1:0] pad_count   = 2'd0;
	logic [2:0] err_code    = b64d_pkg::ST_OK;

	always #2 clk = ~clk;

	base64_stream_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_word  (char_word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word)
	);

	function automatic logic [6:0] sextet_value(input logic [7:0] ch);
		if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
		if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 8'd26);
		if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 8'd52);
		if (ch == b64d_pkg::CH_PLUS || ch == b64d_pkg::CH_DASH) return 7'd62;
		if (ch == b64d_pkg::CH_SLASH || ch == b64d_pkg::CH_UNDER) return 7'd63;
		return 7'h40;
	endfunction

	function automatic logic [7:0] sextet_char(input logic [5:0] s, input bit url);
		if (s < 6'd26) return "A" + 8'(s);
		if (s < 6'd52) return "a" + 8'(s - 6'd26);
		if (s < 6'd62) return "0" + 8'(s - 6'd52);
		if (s == 6'd62) return url ? b64d_pkg::CH_DASH : b64d_pkg::CH_PLUS;
		return url ? b64d_pkg::CH_UNDER : b64d_pkg::CH_SLASH;
	endfunction

	task automatic clear_decoder();
		grp_pos     = 2'd0;
		prev_sextet = 6'd0;
		seen_std    = 1'b0;
		seen_url    = 1'b0;
		pad_count   = 2'd0;
		err_code    = b64d_pkg::ST_OK;
	endtask

	// only the first error of a string is kept
	task automatic note_error(input logic [2:0] code);
		if (err_code == b64d_pkg::ST_OK) err_code = code;
	endtask

	task automatic decode_char(input b64d_pkg::in_word_t w);
		logic [6:0]          v;
		b64d_pkg::out_word_t o;
		o = '0;
		if (err_code == b64d_pkg::ST_OK) begin
			if (w.char_code == b64d_pkg::CH_PAD) begin
				if (pad_count == 2'd0 && grp_pos == 2'd2) begin
					if (prev_sextet[3:0] != 4'd0) note_error(b64d_pkg::ST_TAIL);
					pad_count = 2'd1;
					grp_pos   = 2'd3;
				end else if (pad_count == 2'd0 && grp_pos == 2'd3) begin
					if (prev_sextet[1:0] != 2'd0) note_error(b64d_pkg::ST_TAIL);
					pad_count = 2'd1;
					grp_pos   = 2'd0;
				end else if (pad_count == 2'd1 && grp_pos == 2'd3) begin
					pad_count = 2'd2;
					grp_pos   = 2'd0;
				end else begin
					note_error(b64d_pkg::ST_BAD_PAD);
				end
			end else if (pad_count != 2'd0) begin
				note_error(b64d_pkg::ST_BAD_PAD);
			end else begin
				v = sextet_value(w.char_code);
				if (v[6]) begin
					note_error(b64d_pkg::ST_BAD_CHAR);
				end else begin
					if (w.char_code == b64d_pkg::CH_PLUS ||
						w.char_code == b64d_pkg::CH_SLASH) begin
						if (seen_url) note_error(b64d_pkg::ST_MIXED);
						seen_std = 1'b1;
					end else if (w.char_code == b64d_pkg::CH_DASH ||
						w.char_code == b64d_pkg::CH_UNDER) begin
						if (seen_std) note_error(b64d_pkg::ST_MIXED);
						seen_url = 1'b1;
					end
					if (err_code == b64d_pkg::ST_OK) begin
						if (grp_pos != 2'd0) begin
							case (grp_pos)
								2'd1: o.data_byte = {prev_sextet, v[5:4]};
								2'd2: o.data_byte = {prev_sextet[3:0], v[5:2]};
								default: o.data_byte = {prev_sextet[1:0], v[5:0]};
							endcase
							decoded_words.insert(decoded_words.size(), o);
						end
						prev_sextet = v[5:0];
						grp_pos     = grp_pos + 2'd1;
					end
				end
			end
		end
		if (w.is_last) begin
			if (err_code == b64d_pkg::ST_OK) begin
				if (pad_count != 2'd0) begin
					if (grp_pos != 2'd0) note_error(b64d_pkg::ST_BAD_PAD);
				end else if (grp_pos == 2'd1) begin
					note_error(b64d_pkg::ST_BAD_PAD);
				end else if (grp_pos == 2'd2 && prev_sextet[3:0] != 4'd0) begin
					note_error(b64d_pkg::ST_TAIL);
				end else if (grp_pos == 2'd3 && prev_sextet[1:0] != 2'd0) begin
					note_error(b64d_pkg::ST_TAIL);
				end
			end
			o               = '0;
			o.is_status     = 1'b1;
			o.status_code   = err_code;
			o.end_of_string = 1'b1;
			decoded_words.insert(decoded_words.size(), o);
			clear_decoder();
		end
	endtask

	task automatic push_char(input logic [7:0] c, input bit last);
		b64d_pkg::in_word_t w;
		w.char_code = c;
		w.is_last   = last;
		char_queue.insert(char_queue.size(), w);
		queued_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
	endtask

	task automatic make_random_string();
		text_t      txt;
		text_t      raw;
		int         kind;
		int         nbytes;
		int         pos;
		bit         url;
		bit         padded;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		kind = $urandom_range(99);
		if (kind >= 93) begin
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(3))
					0: txt = {txt, 8'($urandom_range(128, 255))};
					1: txt = {txt, sextet_char(6'($urandom_range(63)),
						1'($urandom_range(1)))};
					2: txt = {txt, b64d_pkg::CH_PAD};
					default: txt = {txt, 8'($urandom_range(255))};
				endcase
			end
		end else begin
			nbytes = $urandom_range(1, 12);
			url    = 1'($urandom_range(1));
			padded = 1'($urandom_range(1));
			// bias towards bytes that map onto the two alphabet-specific symbols
			repeat (nbytes) begin
				if ($urandom_range(3) == 0) raw = {raw, 8'hF8 | 8'($urandom_range(7))};
				else raw = {raw, 8'($urandom_range(255))};
			end
			for (int i = 0; i < nbytes; i += 3) begin
				b0 = raw[i];
				b1 = (i + 1 < nbytes) ? raw[i + 1] : 8'h00;
				b2 = (i + 2 < nbytes) ? raw[i + 2] : 8'h00;
				txt = {txt, sextet_char(b0[7:2], url)};
				txt = {txt, sextet_char({b0[1:0], b1[7:4]}, url)};
				if (i + 1 < nbytes) txt = {txt, sextet_char({b1[3:0], b2[7:6]}, url)};
				else if (padded) txt = {txt, b64d_pkg::CH_PAD};
				if (i + 2 < nbytes) txt = {txt, sextet_char(b2[5:0], url)};
				else if (padded) txt = {txt, b64d_pkg::CH_PAD};
			end
			pos = $urandom_range(txt.size() - 1);
			if (kind >= 86) begin
				// disturb the last data character, usually leaving stray tail bits
				pos = txt.size() - 1;
				while (pos > 0 && txt[pos] == b64d_pkg::CH_PAD) pos--;
				txt[pos] = sextet_char(6'($urandom_range(63)), url);
			end else if (kind >= 78) begin
				case ($urandom_range(3))
					0: txt.delete(txt.size() - 1);
					1: txt = {txt, b64d_pkg::CH_PAD};
					2: txt.insert(pos, b64d_pkg::CH_PAD);
					default: txt = {txt, sextet_char(6'($urandom_range(63)), url)};
				endcase
			end else if (kind >= 70) begin
				txt.insert(pos, sextet_char(6'(62 + $urandom_range(1)), url));
				pos = $urandom_range(txt.size() - 1);
				txt.insert(pos, sextet_char(6'(62 + $urandom_range(1)), !url));
			end else if (kind >= 60) begin
				txt[pos] = 8'($urandom_range(255));
			end
		end
		for (int i = 0; i < txt.size(); i++) push_char(txt[i], i == txt.size() - 1);
	endtask

	// driver: next word can go out at the falling edge after the last was taken, unless the idle draw holds it
	always @(negedge clk) begin
		if (arst_n) begin
			if (!char_valid || char_fired) begin
				if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					char_valid <= 1'b1;
					char_word  <= char_queue.pop_front();
				end else begin
					char_valid <= 1'b0;
				end
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		b64d_pkg::out_word_t want;
		char_fired = arst_n && char_valid && char_ready;
		if (char_fired) decode_char(char_word);
		if (arst_n && res_valid && res_ready) begin
			if (decoded_words.size() == 0) begin
				$error("result word with none expected: %p", res_word);
				failed = 1'b1;
			end else begin
				want = decoded_words.pop_front();
				if (res_word.data_byte !== want.data_byte) begin
					$error("data_byte: expected %h, got %h", want.data_byte, res_word.data_byte);
					failed = 1'b1;
				end
				if (res_word.is_status !== want.is_status) begin
					$error("is_status: expected %b, got %b", want.is_status, res_word.is_status);
					failed = 1'b1;
				end
				if (res_word.status_code !== want.status_code) begin
					$error("status_code: expected %0d, got %0d", want.status_code,
						res_word.status_code);
					failed = 1'b1;
				end
				if (res_word.end_of_string !== want.end_of_string) begin
					$error("end_of_string: expected %b, got %b", want.end_of_string,
						res_word.end_of_string);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 56;
				end
				1: begin
					send_idle_pct = 56;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				push_text("TWFu");
				push_text("TQ==");
				push_text("-_8=");
				push_text("A/_A");
				push_text("TR==");
				push_text("T");
				push_text("=");
				push_char(8'hFF, 1'b1);
				push_char(8'h00, 1'b1);
			end
			while (queued_items < (phase + 1) * ITEMS_PER_PHASE) make_random_string();
			while (char_queue.size() != 0 || char_valid) @(posedge clk);
			// sender holds off until the decoder has drained
			while (decoded_words.size() != 0) @(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (!failed) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
